// ----- rtl/pdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdc_pkg - shared definitions for the packet deframer
// Header byte positions, verdict status codes and the result item layout.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned POS_W        = 9;

  // header byte positions in wire order
  localparam logic [POS_W-1:0] POS_TYPE   = 9'd0;
  localparam logic [POS_W-1:0] POS_HOPS   = 9'd1;
  localparam logic [POS_W-1:0] POS_DST_HI = 9'd2;
  localparam logic [POS_W-1:0] POS_DST_LO = 9'd3;
  localparam logic [POS_W-1:0] POS_SRC_HI = 9'd4;
  localparam logic [POS_W-1:0] POS_SRC_LO = 9'd5;
  localparam logic [POS_W-1:0] POS_CSUM   = 9'd6;
  localparam logic [POS_W-1:0] POS_LEN    = 9'd7;
  localparam logic [POS_W-1:0] POS_MAX    = 9'd511;

  localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_LEN_WRONG = 2'd1,
    ST_CSUM_BAD  = 2'd2,
    ST_NOT_ADDR  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  // one result item; fields listed from the high bit down
  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  payload_length;
    logic [15:0] src_address;
    logic [15:0] dst_address;
    logic [7:0]  hop_count;
    logic [7:0]  packet_type;
    status_t     status;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

// ----- rtl/packet_deframer_checksum.sv -----
// ----------------------------------------------------------------------------
// packet_deframer_checksum - frame header capture and verdict
// Splits received frames into payload bytes and one end-of-frame verdict.
// ----------------------------------------------------------------------------
// Frame bytes enter on the s_ side, one transaction per cycle while s_tready
// is high, s_tlast on the last byte. Bytes 0..7 are the header (type, hops,
// big-endian destination, big-endian source, checksum, payload length);
// every later byte is passed on as a payload transaction (m_tuser 0). On the
// last byte a verdict transaction (m_tuser 1) follows: length wrong, else
// 8-bit additive checksum (all bytes except byte 6) bad, else destination
// neither node_address nor 0xFFFF, else accepted with hops decremented unless
// zero. Downstream must drop payload already passed on when the verdict is a
// reject. Each byte goes through the input register and the header/checksum
// logic into an 8-entry result queue; one byte per cycle is sustained while
// the output side keeps up, and a last payload byte that also yields a verdict
// pushes two results, which the queue absorbs as the output side drains one
// transaction per cycle when m_tready is high. The user writes node_address
// through cfg_wen/cfg_wdata only while the block is idle (not enforced here).
// ----------------------------------------------------------------------------
module packet_deframer_checksum
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,     // node_address
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // rx_byte
  input  logic        s_tlast,       // frame_end
  // result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,       // payload_byte[7:0], status[9:8],
                                     // packet_type[17:10], hop_count[25:18],
                                     // dst_address[41:26], src_address[57:42],
                                     // payload_length[65:58], zero[71:66]
  output logic        m_tuser        // result_kind
);

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = 3;
  localparam int unsigned QCNT_W = 4;

  logic [15:0] node_address;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // frame state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  hops_reg, hops_reg_next;
  logic [15:0] dst_reg, dst_reg_next;
  logic [15:0] src_reg, src_reg_next;
  logic [7:0]  received_checksum, received_checksum_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [7:0]  running_sum, running_sum_next;

  // result queue
  result_t           queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  logic        in_fire, out_fire;
  logic        is_payload;
  logic [9:0]  total_len, expect_len;
  status_t     verdict_status;
  logic [7:0]  verdict_hops;
  result_t     payload_item, verdict_item;
  logic [1:0]  push_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
    end else if (cfg_wen) begin
      node_address <= cfg_wdata;
    end
  end

  // room for the item in the input register plus the next one, two results each
  assign s_tready = ({1'b0, count} + (in_valid ? 5'd2 : 5'd0)) <= 5'(QDEPTH - 2);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // header capture and running checksum
  always_comb begin
    type_reg_next          = type_reg;
    hops_reg_next          = hops_reg;
    dst_reg_next           = dst_reg;
    src_reg_next           = src_reg;
    received_checksum_next = received_checksum;
    length_reg_next        = length_reg;
    case (byte_position)
      POS_TYPE:   type_reg_next          = in_byte;
      POS_HOPS:   hops_reg_next          = in_byte;
      POS_DST_HI: dst_reg_next           = {in_byte, dst_reg[7:0]};
      POS_DST_LO: dst_reg_next           = {dst_reg[15:8], in_byte};
      POS_SRC_HI: src_reg_next           = {in_byte, src_reg[7:0]};
      POS_SRC_LO: src_reg_next           = {src_reg[15:8], in_byte};
      POS_CSUM:   received_checksum_next = in_byte;
      POS_LEN:    length_reg_next        = in_byte;
      default:    ;
    endcase
    running_sum_next   = (byte_position != POS_CSUM) ? running_sum + in_byte : running_sum;
    byte_position_next = (byte_position != POS_MAX) ? byte_position + 9'd1 : byte_position;
    is_payload         = byte_position >= POS_W'(HEADER_BYTES);
  end

  // verdict on the frame's final state
  always_comb begin
    total_len  = {1'b0, byte_position} + 10'd1;
    expect_len = {2'b00, length_reg_next} + 10'(HEADER_BYTES);
    if (total_len != expect_len) begin
      verdict_status = ST_LEN_WRONG;
    end else if (running_sum_next != received_checksum_next) begin
      verdict_status = ST_CSUM_BAD;
    end else if (dst_reg_next != node_address && dst_reg_next != BROADCAST_ADDR) begin
      verdict_status = ST_NOT_ADDR;
    end else begin
      verdict_status = ST_ACCEPTED;
    end
    verdict_hops = hops_reg_next;
    if (verdict_status == ST_ACCEPTED && hops_reg_next != 8'd0) begin
      verdict_hops = hops_reg_next - 8'd1;
    end

    payload_item              = '0;
    payload_item.result_kind  = KIND_PAYLOAD;
    payload_item.status       = ST_ACCEPTED;
    payload_item.payload_byte = in_byte;

    verdict_item                = '0;
    verdict_item.result_kind    = KIND_VERDICT;
    verdict_item.status         = verdict_status;
    verdict_item.packet_type    = type_reg_next;
    verdict_item.hop_count      = verdict_hops;
    verdict_item.dst_address    = dst_reg_next;
    verdict_item.src_address    = src_reg_next;
    verdict_item.payload_length = length_reg_next;

    push_n = in_valid ? ({1'b0, is_payload} + {1'b0, in_last}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      type_reg          <= '0;
      hops_reg          <= '0;
      dst_reg           <= '0;
      src_reg           <= '0;
      received_checksum <= '0;
      length_reg        <= '0;
      running_sum       <= '0;
    end else if (in_valid) begin
      if (in_last) begin
        // verdict given, ready for the next frame
        byte_position     <= '0;
        type_reg          <= '0;
        hops_reg          <= '0;
        dst_reg           <= '0;
        src_reg           <= '0;
        received_checksum <= '0;
        length_reg        <= '0;
        running_sum       <= '0;
      end else begin
        byte_position     <= byte_position_next;
        type_reg          <= type_reg_next;
        hops_reg          <= hops_reg_next;
        dst_reg           <= dst_reg_next;
        src_reg           <= src_reg_next;
        received_checksum <= received_checksum_next;
        length_reg        <= length_reg_next;
        running_sum       <= running_sum_next;
      end
    end
  end

  // result queue: payload first, verdict after it in the same cycle
  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (is_payload) begin
        queue[wr_ptr] <= payload_item;
        if (in_last) begin
          queue[wr_ptr + 3'd1] <= verdict_item;
        end
      end else if (in_last) begin
        queue[wr_ptr] <= verdict_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (out_fire) begin
        rd_ptr <= rd_ptr + 3'd1;
      end
      count <= count + QCNT_W'(push_n) - (out_fire ? 4'd1 : 4'd0);
    end
  end

  assign m_tvalid = count != '0;
  assign m_tuser  = queue[rd_ptr].result_kind;
  assign m_tdata  = {6'b0, queue[rd_ptr].payload_length, queue[rd_ptr].src_address,
                     queue[rd_ptr].dst_address, queue[rd_ptr].hop_count,
                     queue[rd_ptr].packet_type, queue[rd_ptr].status,
                     queue[rd_ptr].payload_byte};

  // ---- assertions ----
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_no_push_overflow: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ({1'b0, count} + 5'(push_n)) <= 5'(QDEPTH))
    else $error("push into full result queue");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_last) |=> (byte_position == '0 && running_sum == '0))
    else $error("frame state not cleared after verdict");

  a_accept_addressed: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_last && verdict_status == ST_ACCEPTED) |->
      (dst_reg_next == node_address || dst_reg_next == BROADCAST_ADDR))
    else $error("accepted frame not addressed to this node");

endmodule

// ----- bench/deframe_checker.sv -----
// ----------------------------------------------------------------------------
// deframe_checker - result predictor and comparator for the deframer
// Watches the byte, result and config channels, predicts every result
// transaction from the accepted bytes and compares field by field.
// ----------------------------------------------------------------------------
module deframe_checker
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tuser,
  output int          outstanding,
  output int          failures
);

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    status_t     status;
    logic [7:0]  ptype;
    logic [7:0]  hops;
    logic [15:0] dst;
    logic [15:0] src;
    logic [7:0]  len;
  } deframe_out_t;

  // predicted frame state
  logic [15:0] my_addr;
  logic [8:0]  frame_pos;
  logic [7:0]  ptype_q, hops_q, csum_q, len_q, sum_q;
  logic [15:0] dst_q, src_q;

  deframe_out_t due_results[$];

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    deframe_out_t item;
    deframe_out_t want;
    logic [8:0]   pos;
    logic [7:0]   b;
    if (rst) begin
      failures  = 0;
      my_addr   = '0;
      frame_pos = '0;
      {ptype_q, hops_q, csum_q, len_q, sum_q} = '0;
      {dst_q, src_q} = '0;
      due_results.delete();
    end else begin
      if (cfg_wen)
        my_addr = cfg_wdata;

      if (s_tvalid && s_tready) begin
        b   = s_tdata;
        pos = frame_pos;
        case (pos)
          POS_TYPE:   ptype_q = b;
          POS_HOPS:   hops_q = b;
          POS_DST_HI: dst_q[15:8] = b;
          POS_DST_LO: dst_q[7:0] = b;
          POS_SRC_HI: src_q[15:8] = b;
          POS_SRC_LO: src_q[7:0] = b;
          POS_CSUM:   csum_q = b;
          POS_LEN:    len_q = b;
          default: ;
        endcase
        if (pos != POS_CSUM)
          sum_q = sum_q + b;

        // payload bytes go straight through
        if (pos >= HEADER_BYTES) begin
          item = '{KIND_PAYLOAD, b, ST_ACCEPTED, 8'h0, 8'h0, 16'h0, 16'h0, 8'h0};
          due_results.push_back(item);
        end
        if (pos != POS_MAX)
          frame_pos = pos + 9'd1;

        if (s_tlast) begin
          item = '{KIND_VERDICT, 8'h0, ST_ACCEPTED, ptype_q, hops_q, dst_q, src_q, len_q};
          if (int'(pos) + 1 != int'(len_q) + int'(HEADER_BYTES))
            item.status = ST_LEN_WRONG;
          else if (sum_q != csum_q)
            item.status = ST_CSUM_BAD;
          else if (dst_q != my_addr && dst_q != BROADCAST_ADDR)
            item.status = ST_NOT_ADDR;
          if (item.status == ST_ACCEPTED && hops_q != 8'h0)
            item.hops = hops_q - 8'd1;
          due_results.push_back(item);
          frame_pos = '0;
          {ptype_q, hops_q, csum_q, len_q, sum_q} = '0;
          {dst_q, src_q} = '0;
        end
      end

      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result transaction: tuser %0b tdata 0x%0h", m_tuser, m_tdata);
          failures++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind",    16'(want.kind),   16'(m_tuser));
          check_field("payload_byte",   16'(want.data),   16'(m_tdata[7:0]));
          check_field("status",         16'(want.status), 16'(m_tdata[9:8]));
          check_field("packet_type",    16'(want.ptype),  16'(m_tdata[17:10]));
          check_field("hop_count",      16'(want.hops),   16'(m_tdata[25:18]));
          check_field("dst_address",    want.dst,         m_tdata[41:26]);
          check_field("src_address",    want.src,         m_tdata[57:42]);
          check_field("payload_length", 16'(want.len),    16'(m_tdata[65:58]));
          check_field("tdata_pad",      16'h0,            16'(m_tdata[71:66]));
        end
      end
    end
    outstanding = due_results.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - testbench for packet_deframer_checksum
// Sends directed and random frames (good, bad checksum, wrong length, short,
// oversized, saturating) under several node addresses, with random gaps on
// the byte side and random stalls on the result side; deframe_checker
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_top
  import pdc_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;  // idle cycles before giving up
  localparam int SETTLE_CYCLES  = 6;     // block latency plus margin
  localparam int ITEM_TARGET    = 1300;  // byte transactions in total
  localparam int PHASES         = 6;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_wen   = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;     // rx_byte
  logic        s_tlast   = 1'b0;   // frame_end
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [71:0] m_tdata;            // payload_byte, status, packet_type, hop_count,
                                   // dst_address, src_address, payload_length, pad
  logic        m_tuser;            // result_kind

  int outstanding;      // results still owed by the block
  int failures;         // mismatches seen by the checker
  int sent        = 0;  // byte transactions accepted so far
  int ready_hold  = 0;
  int idle_cycles = 0;

  bit          gaps_on  = 1'b0;  // sender inserts idle gaps
  bit          stall_on = 1'b0;  // receiver drops tready
  logic [15:0] node_addr = '0;   // last address written, used to aim frames
  logic [7:0]  tx_frame[$];      // frame under construction

  packet_deframer_checksum dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  deframe_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .outstanding (outstanding),
    .failures    (failures)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap length: random, with a long one now and then.
  function automatic int random_gap();
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Result side: tready held for random stretches, stalls only when enabled.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      m_tready   <= 1'b0;
      ready_hold <= random_gap();
    end else begin
      m_tready   <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end
  end

  // Watchdog: a run of cycles with no transaction on either side is a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One byte transaction. Returns at the edge where it was accepted; valid
  // is either kept high for the next byte or dropped for a gap, never both.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = random_gap();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < tx_frame.size(); i++)
      send_byte(tx_frame[i], i == tx_frame.size() - 1);
  endtask

  // Builds a frame: header, npay random payload bytes, checksum over every
  // byte but the checksum byte itself, optionally spoiled.
  task automatic make_frame(input logic [7:0] ptype, input logic [7:0] hops,
                            input logic [15:0] dst, input logic [15:0] src,
                            input logic [7:0] len, input int npay,
                            input bit bad_sum);
    logic [7:0] sum;
    tx_frame.delete();
    tx_frame = '{ptype, hops, dst[15:8], dst[7:0], src[15:8], src[7:0], 8'h00, len};
    repeat (npay) tx_frame.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    foreach (tx_frame[i])
      if (i != POS_CSUM)
        sum = sum + tx_frame[i];
    tx_frame[POS_CSUM] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
  endtask

  // Stop sending and wait for every owed result, plus the block's latency.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Node address is only written with the block idle.
  task automatic write_node(input logic [15:0] addr);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= addr;
    node_addr = addr;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  initial begin
    int          pick;
    int          npay;
    logic [7:0]  len;
    logic [7:0]  hops;
    logic [15:0] dst;
    logic [15:0] addr;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed frames, back to back ----
    write_node(16'hA5C3);
    // one-byte frame: everything but the type reads as zero, length wrong
    make_frame(8'hFF, 8'h12, 16'hA5C3, 16'h1111, 8'd0, 0, 1'b0);
    tx_frame = tx_frame[0:0];
    send_frame();
    // bare header to broadcast, hops zero stays zero
    make_frame(8'h00, 8'h00, BROADCAST_ADDR, 16'h0000, 8'd0, 0, 1'b0);
    send_frame();
    // one byte past the declared payload: still passed on, length wrong wins
    // over the spoiled checksum
    make_frame(8'h7E, 8'h05, 16'h0001, 16'hFFFF, 8'd0, 1, 1'b1);
    send_frame();
    // checksum bad beats the address miss; hops kept on reject
    make_frame(8'h80, 8'hFF, 16'h5A3C, 16'h8000, 8'd0, 0, 1'b1);
    send_frame();

    // ---- random phases, each under its own node address ----
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       addr = 16'hFFFF;
        1:       addr = 16'h0000;
        default: addr = 16'($urandom_range(0, 65535));
      endcase
      write_node(addr);
      // some phases run with no idling at all on one side or both
      gaps_on  = (p % 3 != 2);
      stall_on = (p % 3 != 1) && (p != 5);

      if (p == 3) begin
        // runs past 511 bytes: position saturates, length never matches
        make_frame(8'($urandom_range(0, 255)), 8'h03, node_addr, 16'h1234,
                   8'($urandom_range(0, 255)), 520, 1'b0);
        send_frame();
      end
      if (p == 4) begin
        // largest well-formed frame
        make_frame(8'h55, 8'h01, node_addr, 16'hC0DE, 8'd255, 255, 1'b0);
        send_frame();
      end

      while (sent < 25 + (p + 1) * (ITEM_TARGET / PHASES)) begin
        pick = $urandom_range(0, 9);
        if (pick < 4)      dst = node_addr;
        else if (pick < 6) dst = BROADCAST_ADDR;
        else if (pick < 7) dst = node_addr ^ 16'(1 << $urandom_range(0, 15));
        else               dst = 16'($urandom_range(0, 65535));

        case ($urandom_range(0, 4))
          0:       hops = 8'h00;
          1:       hops = 8'h01;
          2:       hops = 8'hFF;
          default: hops = 8'($urandom_range(0, 255));
        endcase

        npay = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        len  = 8'(npay);
        pick = $urandom_range(0, 19);
        if (pick == 16 || pick == 17)
          do len = 8'($urandom_range(0, 45)); while (len == 8'(npay));

        make_frame(8'($urandom_range(0, 255)), hops, dst, 16'($urandom_range(0, 65535)),
                   len, npay, pick >= 13 && pick <= 15);
        // short frame: cut somewhere inside the header
        if (pick >= 18)
          tx_frame = tx_frame[0:$urandom_range(0, HEADER_BYTES - 2)];
        send_frame();

        // now and then hold off until the block has fully drained
        if ($urandom_range(0, 39) == 0)
          settle();
      end
    end

    settle();
    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
